// ===== src/signed_int_to_radix_ascii_defines.svh =====
// ----------------------------------------------------------------------------
// signed_int_to_radix_ascii assertion macros
// Shared concurrent assertion forms for the radix text converter checker.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_RADIX_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_RADIX_ASCII_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define SIRC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define SIRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also watches the reset cycles
`define SIRC_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sirc_pkg.sv =====
// ----------------------------------------------------------------------------
// sirc_pkg
// Types, constants and character mapping shared by the radix text converter.
// ----------------------------------------------------------------------------
package sirc_pkg;

   localparam int VALUE_BITS_DEF = 32;
   // quotient bits resolved per divider cycle
   localparam int DIV_STEP       = 8;

   localparam int RADIX_BITS     = 6;
   localparam int CHAR_BITS      = 7;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 7;

   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO    = 7'd48;
   localparam logic [CHAR_BITS-1:0]  CHAR_UPPER_A = 7'd65;
   localparam logic [CHAR_BITS-1:0]  CHAR_MINUS   = 7'd45;
   localparam logic [RADIX_BITS-1:0] HEX_RADIX    = 6'd16;
   localparam logic [RADIX_BITS-1:0] DECIMAL_TEN  = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN    = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX    = 6'd36;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET  = 6'd10;
   localparam logic [CHAR_BITS-1:0]  LETTER_RESET = 7'd65;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RADIX        = 1'b0,
      CSR_LETTER_START = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [RADIX_BITS-1:0] radix;
      logic [CHAR_BITS-1:0]  letter_start;
   } cfg_type;

   typedef struct packed {
      logic                  strobe;  // a digit is complete this cycle
      logic                  last;    // remaining quotient is zero
      logic [RADIX_BITS-1:0] digit;
   } div_status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_EMIT
   } back_state_type;

   function automatic logic [RADIX_BITS-1:0] eff_radix(input logic [RADIX_BITS-1:0] raw);
      logic [RADIX_BITS-1:0] r;
      priority if (raw < RADIX_MIN) r = RADIX_MIN;
      else if (raw > RADIX_MAX)     r = RADIX_MAX;
      else                          r = raw;
      return r;
   endfunction

   function automatic logic [CHAR_BITS-1:0] map_digit(
      input logic [RADIX_BITS-1:0] digit,
      input logic [RADIX_BITS-1:0] radix,
      input logic [CHAR_BITS-1:0]  letter_start
   );
      logic [CHAR_BITS-1:0] start;
      logic [CHAR_BITS-1:0] ch;
      start = (radix == HEX_RADIX) ? CHAR_UPPER_A : letter_start;
      if (digit < DECIMAL_TEN) begin
         ch = CHAR_ZERO + {1'b0, digit};
      end else begin
         ch = start + {1'b0, digit} - {1'b0, DECIMAL_TEN};
      end
      return ch;
   endfunction

endpackage

// ===== src/sirc_front.sv =====
// ----------------------------------------------------------------------------
// sirc_front
// Accepts integers, splits off the sign and magnitude, and queues them.
// ----------------------------------------------------------------------------
module sirc_front
   import sirc_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  item_valid,
   input  logic                  item_ready,
   output logic                  item_negative,
   output logic [VALUE_BITS-1:0] item_magnitude
);

   localparam int DEPTH = 2;

   logic [VALUE_BITS-1:0] mag_ff [DEPTH];
   logic                  neg_ff [DEPTH];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            fill_ff, fill_in;

   logic                  push;
   logic                  pop;
   logic                  negative;
   logic [VALUE_BITS-1:0] magnitude;

   // two's complement magnitude, exact for the minimum integer as unsigned
   assign negative  = req_value[VALUE_BITS-1];
   assign magnitude = negative ? (~req_value + VALUE_BITS'(1)) : req_value;

   assign req_ready      = (fill_ff != 2'(DEPTH));
   assign item_valid     = (fill_ff != 2'd0);
   assign item_negative  = neg_ff[rd_ptr_ff];
   assign item_magnitude = mag_ff[rd_ptr_ff];

   assign push = req_valid && req_ready;
   assign pop  = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mag_ff[wr_ptr_ff] <= magnitude;
         neg_ff[wr_ptr_ff] <= negative;
      end
   end

endmodule

// ===== src/sirc_divider.sv =====
// ----------------------------------------------------------------------------
// sirc_divider
// Repeated division by the radix, several quotient bits per cycle.
// ----------------------------------------------------------------------------
module sirc_divider
   import sirc_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [RADIX_BITS-1:0] radix,
   output div_status_type        status
);

   localparam int PAD_BITS  = ((VALUE_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
   localparam int STEPS     = PAD_BITS / DIV_STEP;
   localparam int STEP_BITS = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic                  busy_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [RADIX_BITS-1:0] rem_ff;
   logic [PAD_BITS-1:0]   work_ff;

   logic [RADIX_BITS-1:0] rem_next;
   logic [DIV_STEP-1:0]   qbits;
   logic [PAD_BITS-1:0]   work_next;
   logic                  last_step;

   // restoring division on narrow remainders: dividend shifts out at the top,
   // quotient bits shift in at the bottom
   always_comb begin
      logic [RADIX_BITS:0] trial;
      logic [RADIX_BITS-1:0] rem;
      rem   = rem_ff;
      qbits = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial = {rem, work_ff[PAD_BITS-1-i]};
         if (trial >= {1'b0, radix}) begin
            trial                 = trial - {1'b0, radix};
            qbits[DIV_STEP-1-i]   = 1'b1;
         end
         rem = trial[RADIX_BITS-1:0];
      end
      rem_next  = rem;
      work_next = (work_ff << DIV_STEP) | PAD_BITS'(qbits);
   end

   assign last_step     = (step_ff == STEP_BITS'(STEPS - 1));
   assign status.strobe = busy_ff && last_step;
   assign status.last   = (work_next == '0);
   assign status.digit  = rem_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         if (last_step) begin
            step_ff <= '0;
            if (work_next == '0) begin
               busy_ff <= 1'b0;
            end
         end else begin
            step_ff <= step_ff + STEP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         work_ff <= PAD_BITS'(dividend);
         rem_ff  <= '0;
      end else if (busy_ff) begin
         work_ff <= work_next;
         rem_ff  <= last_step ? '0 : rem_next;
      end
   end

endmodule

// ===== src/sirc_back.sv =====
// ----------------------------------------------------------------------------
// sirc_back
// Gathers digits from the divider and emits the text, most significant first.
// ----------------------------------------------------------------------------
module sirc_back
   import sirc_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  logic                  item_negative,
   input  logic [VALUE_BITS-1:0] item_magnitude,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_BITS-1:0]  rsp_character,
   output logic                  rsp_last
);

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
   localparam int IDX_BITS = $clog2(VALUE_BITS);

   back_state_type        state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  minus_ff, minus_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  char_ff;
   logic                  last_ff;
   logic [RADIX_BITS-1:0] digit_store_ff [VALUE_BITS];

   logic                  div_load;
   div_status_type        div_status;
   logic [RADIX_BITS-1:0] radix;
   logic                  out_free;
   logic                  load_out;
   logic [CHAR_BITS-1:0]  out_char;
   logic                  out_last;

   assign radix = eff_radix(cfg.radix);

   sirc_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (item_magnitude),
      .radix    (radix),
      .status   (div_status)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      minus_in   = minus_ff;
      item_ready = 1'b0;
      div_load   = 1'b0;
      load_out   = 1'b0;
      out_char   = CHAR_MINUS;
      out_last   = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               div_load = 1'b1;
               count_in = '0;
               minus_in = item_negative;
               state_in = BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            if (div_status.strobe) begin
               count_in = count_ff + CNT_BITS'(1);
               if (div_status.last) begin
                  // old count is the index of the most significant digit
                  idx_in   = count_ff[IDX_BITS-1:0];
                  state_in = BACK_EMIT;
               end
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               if (minus_ff) begin
                  minus_in = 1'b0;
               end else begin
                  out_char = map_digit(digit_store_ff[idx_ff], radix, cfg.letter_start);
                  out_last = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = BACK_IDLE;
                  end else begin
                     idx_in = idx_ff - IDX_BITS'(1);
                  end
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         minus_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         minus_ff     <= minus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BACK_DIVIDE && div_status.strobe) begin
         digit_store_ff[count_ff[IDX_BITS-1:0]] <= div_status.digit;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         char_ff <= out_char;
         last_ff <= out_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== src/signed_int_to_radix_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_radix_ascii
// Signed integer to ASCII text in a configurable base, one character a word.
// ----------------------------------------------------------------------------
// Usage:
//   req_* stream: one signed integer a word. rsp_* stream: one ASCII character
//   a word, most significant first, a leading '-' for negative values, tlast
//   on the final character. csr_* port: index 0 sets the radix (clamped to
//   2..36), index 1 the letter code for digit ten ('A' is used for base 16).
//   Write it only while no conversion is in flight.
// Conversion:
//   the divider resolves 8 quotient bits a cycle and makes one full pass over
//   the padded magnitude for each digit, least significant digit first; the
//   digits then go out through the output register one character at a time,
//   after a leading '-' for a negative value.
//   A two-word input queue lets the next integer be taken while the current
//   one is still converting.
// Reset: clears the queue, the sequencer and rsp_tvalid; radix 10, letter 'A'.
// Stall: a held rsp_tready freezes the output word and the emit sequencer.
// ----------------------------------------------------------------------------
module signed_int_to_radix_ascii
   import sirc_pkg::*;
#(
   parameter  int VALUE_BITS    = VALUE_BITS_DEF,
   localparam int REQ_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // value
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // character, zero pad
   output logic                      rsp_tlast,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type               cfg_ff;
   logic                  item_valid;
   logic                  item_ready;
   logic                  item_negative;
   logic [VALUE_BITS-1:0] item_magnitude;
   logic [CHAR_BITS-1:0]  rsp_character;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radix        <= RADIX_RESET;
         cfg_ff.letter_start <= LETTER_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_RADIX:        cfg_ff.radix        <= csr_data[RADIX_BITS-1:0];
            CSR_LETTER_START: cfg_ff.letter_start <= csr_data;
            default: begin
            end
         endcase
      end
   end

   sirc_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_value      (req_tdata[VALUE_BITS-1:0]),
      .item_valid     (item_valid),
      .item_ready     (item_ready),
      .item_negative  (item_negative),
      .item_magnitude (item_magnitude)
   );

   sirc_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .item_valid     (item_valid),
      .item_ready     (item_ready),
      .item_negative  (item_negative),
      .item_magnitude (item_magnitude),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_character};

endmodule

// ===== src/sirc_checker.sv =====
// ----------------------------------------------------------------------------
// sirc_checker
// Port-level checks for the radix text converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_int_to_radix_ascii_defines.svh"

module sirc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       csr_ready
);

   // a stalled output word stays put
   `SIRC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp word changed while stalled")

   // reset empties the output register and the input queue
   `SIRC_ASSERT_RESET(a_reset_clear, reset, !rsp_tvalid && req_tready, "reset did not clear the channels")

   // characters are 7-bit ascii, the pad bit stays low
   `SIRC_ASSERT_NOW(a_char_pad, rsp_tvalid, !rsp_tdata[7], "character pad bit set")

   // register writes are never back-pressured
   `SIRC_ASSERT_NOW(a_csr_ready, 1'b1, csr_ready, "csr port not ready")

endmodule

bind signed_int_to_radix_ascii sirc_checker u_checker (.*);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signed integer to radix text converter: a short
// table of directed values, then random values under random radix and letter
// settings, every character checked against the table text or a local predictor.
// ----------------------------------------------------------------------------
module tb
   import sirc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [CHAR_BITS-1:0] code;
      logic                 last_char;
   } text_char_type;

   typedef struct {
      logic [RADIX_BITS-1:0] radix;
      logic [CHAR_BITS-1:0]  letter;
      logic [31:0]           value;
      string                 text;
   } directed_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [31:0]               req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [7:0]                rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   text_char_type         pending_chars[$];
   logic [RADIX_BITS-1:0] cur_radix;
   logic [CHAR_BITS-1:0]  cur_letter;
   int                    error_count;
   int                    tx_idle_pct;
   int                    rx_idle_pct;
   bit                    hold_request;

   // empty text means the predictor supplies the characters
   directed_row_type directed_rows [0:22] = '{
      '{6'd10, 7'd65,  32'd0,          "0"},
      '{6'd10, 7'd65,  32'h7FFFFFFF,   "2147483647"},
      '{6'd10, 7'd65,  32'h80000000,   "-2147483648"},
      '{6'd10, 7'd65,  32'hFFFFFFFF,   "-1"},
      '{6'd10, 7'd65,  32'd255,        "255"},
      '{6'd2,  7'd65,  32'h80000000,   ""},
      '{6'd2,  7'd65,  32'h7FFFFFFF,   ""},
      '{6'd2,  7'd65,  32'd0,          "0"},
      '{6'd36, 7'd65,  32'h7FFFFFFF,   "ZIK0ZJ"},
      '{6'd36, 7'd65,  32'hFFFFFFDC,   "-10"},
      '{6'd36, 7'd65,  32'd35,         "Z"},
      '{6'd16, 7'd97,  32'h7FFFFFFF,   "7FFFFFFF"},
      '{6'd16, 7'd97,  32'h80000000,   "-80000000"},
      '{6'd16, 7'd97,  32'h00ABCDEF,   "ABCDEF"},
      '{6'd0,  7'd33,  32'd5,          "101"},
      '{6'd0,  7'd33,  32'hFFFFFFFE,   "-10"},
      '{6'd63, 7'd127, 32'd35,         ""},
      '{6'd63, 7'd127, 32'h80000000,   ""},
      '{6'd12, 7'd100, 32'd11,         "e"},
      '{6'd12, 7'd100, 32'd143,        "ee"},
      '{6'd37, 7'd33,  32'd36,         "10"},
      '{6'd37, 7'd33,  32'd35,         ""},
      '{6'd1,  7'd100, 32'h55555555,   ""}
   };

   signed_int_to_radix_ascii DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // value
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // character, zero pad
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // appends the characters of one value as the converter should emit them
   function automatic void predict_radix_text(input logic [31:0] value);
      logic [31:0]          mag;
      logic [5:0]           digits [0:31];
      logic [CHAR_BITS-1:0] start;
      int unsigned          base;
      int                   n;
      text_char_type        ch;
      base = 32'((cur_radix < RADIX_MIN) ? RADIX_MIN :
                 (cur_radix > RADIX_MAX) ? RADIX_MAX : cur_radix);
      start = (base == HEX_RADIX) ? CHAR_UPPER_A : cur_letter;
      // two's complement negate also covers the minimum integer
      mag = value[31] ? (~value + 32'd1) : value;
      n = 0;
      do begin
         digits[n] = 6'(mag % base);
         n++;
         mag = mag / base;
      end while (mag != 0);
      if (value[31]) begin
         ch.code = CHAR_MINUS;
         ch.last_char = 1'b0;
         pending_chars.push_back(ch);
      end
      for (int k = n - 1; k >= 0; k--) begin
         if (digits[k] < DECIMAL_TEN) begin
            ch.code = CHAR_ZERO + CHAR_BITS'(digits[k]);
         end else begin
            // letter code wraps within seven bits
            ch.code = start + CHAR_BITS'(digits[k]) - CHAR_BITS'(DECIMAL_TEN);
         end
         ch.last_char = (k == 0);
         pending_chars.push_back(ch);
      end
   endfunction

   function automatic logic [31:0] pick_value();
      int unsigned base;
      int          kind;
      int          k;
      logic [31:0] p;
      base = 32'((cur_radix < RADIX_MIN) ? RADIX_MIN :
                 (cur_radix > RADIX_MAX) ? RADIX_MAX : cur_radix);
      kind = $urandom_range(99);
      if (kind < 40) begin
         return $urandom;
      end else if (kind < 65) begin
         return $urandom_range(200) - 100;
      end else if (kind < 80) begin
         case ($urandom_range(4))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'd0;
            3: return 32'hFFFFFFFF;
            default: return 32'd1;
         endcase
      end
      // around a power of the base, where the digit count changes
      p = 32'd1;
      k = $urandom_range(1, 31);
      repeat (k) begin
         if (p <= 32'h7FFFFFFF / base) p = p * base;
      end
      p = p + $urandom_range(2) - 1;
      if ($urandom_range(1)) p = ~p + 32'd1;
      return p;
   endfunction

   // called at a falling edge; leaves req_tvalid high after the word is taken
   task automatic offer_value(input logic [31:0] value, input string text);
      text_char_type ch;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      if (text.len() == 0) begin
         predict_radix_text(value);
      end else begin
         for (int i = 0; i < text.len(); i++) begin
            ch.code = CHAR_BITS'(text[i]);
            ch.last_char = (i == text.len() - 1);
            pending_chars.push_back(ch);
         end
      end
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_RADIX) cur_radix = data[RADIX_BITS-1:0];
      else                  cur_letter = data;
      @(negedge clock);
   endtask

   // only once the converter has drained every character
   task automatic set_config(input logic [RADIX_BITS-1:0] radix,
                             input logic [CHAR_BITS-1:0] letter);
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
      write_reg(CSR_RADIX, CSR_DATA_BITS'(radix));
      write_reg(CSR_LETTER_START, letter);
      csr_valid <= 1'b0;
   endtask

   // receiver, with one long hold-off on request
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected word: character %0d, last_char %0b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_tdata !== {1'b0, want.code}) begin
               $error("character: expected %0d, actual %0d", want.code, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.last_char) begin
               $error("last_char: expected %0b, actual %0b", want.last_char, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [RADIX_BITS-1:0] radix;
      logic [CHAR_BITS-1:0]  letter;
      error_count  = 0;
      tx_idle_pct  = 17;
      rx_idle_pct  = 17;
      hold_request = 1'b0;
      cur_radix    = RADIX_RESET;
      cur_letter   = LETTER_RESET;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_RADIX;
      csr_data     = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // leading rows run on the reset settings
      foreach (directed_rows[i]) begin
         if (directed_rows[i].radix != cur_radix || directed_rows[i].letter != cur_letter)
            set_config(directed_rows[i].radix, directed_rows[i].letter);
         offer_value(directed_rows[i].value, directed_rows[i].text);
      end

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 1)
            radix = HEX_RADIX;
         else if ($urandom_range(3) == 0)
            radix = RADIX_BITS'($urandom_range(63));
         else
            radix = RADIX_BITS'($urandom_range(RADIX_MIN, RADIX_MAX));
         letter = CHAR_BITS'($urandom_range(127));
         set_config(radix, letter);
         tx_idle_pct = (phase == 2) ? 0 : 17;
         rx_idle_pct = (phase == 2) ? 0 : 17;
         // the receiver stops while words keep coming, so the input queue fills
         if (phase == 3) hold_request = 1'b1;
         repeat (24) offer_value(pick_value(), "");
      end

      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== signed_int_to_radix_ascii.f =====
+incdir+src
src/sirc_pkg.sv
src/sirc_front.sv
src/sirc_divider.sv
src/sirc_back.sv
src/signed_int_to_radix_ascii.sv
src/sirc_checker.sv
dv/tb.sv
